// ----- hw/rtl/ngsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ngsc_pkg
// shared types, constants and the arctangent table for the steering core
// ----------------------------------------------------------------------------
package ngsc_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned MaxTable    = 24;
  localparam int unsigned NumCells    = (CordicSteps < MaxTable) ? CordicSteps : MaxTable;
  localparam int unsigned CntW        = $clog2(NumCells + 1);
  localparam int unsigned IdxW        = $clog2(MaxTable);

  // cordic datapath widths: diff*256 is 25 bits signed, growth < 2x
  localparam int unsigned XyW  = 28;
  localparam int unsigned AngW = 24;

  localparam logic signed [AngW-1:0] AngPi    = 24'sd3294199;
  localparam logic signed [AngW+1:0] AngTwoPi = 26'sd6588398;
  localparam logic [15:0]            InvGain  = 16'd39797;

  typedef enum logic [1:0] {
    OP_POSE  = 2'd0,
    OP_GOAL  = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_LIN_GAIN = 2'd0,
    REG_ANG_GAIN = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_SCALE,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AngW-1:0] z;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [IdxW-1:0] idx);
    logic signed [AngW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/nearest_goal_steering_controller_core.sv -----
// ----------------------------------------------------------------------------
// nearest_goal_steering_controller_core
// nearest-target tracker with proportional go-to-goal speed commands
// ----------------------------------------------------------------------------
// Target elements and empty-list beats are taken while idle and give no output.
// A pose beat with a valid goal runs through a row of CordicSteps cordic cells
// (one cell per cycle) and then scale, multiply and output stages: the command
// is registered in the output stage and the next beat is taken once the core
// is back in idle. A command waiting on the output does not hold off new beats;
// only the next command stalls until it has been handed on. A pose beat without
// a goal skips the cordic row and gives an all-zero command.
module nearest_goal_steering_controller_core
  import ngsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  // pos_x[15:0], pos_y[31:16], heading[46:32], goal_id[62:47],
  // first_of_list[63]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // linear_speed[23:0], angular_speed[47:24], capture_request[48],
  // capture_id[64:49], zero fill to 72
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [15:0] lin_gain_q, ang_gain_q, radius_q;
  logic pose_known_q, goal_valid_q;
  logic [15:0] pose_x_q, pose_y_q, goal_x_q, goal_y_q, goal_id_q;
  logic signed [14:0] heading_q;
  logic [32:0] best_q;
  logic [CntW-1:0] cnt_q;
  logic [71:0] out_q;
  logic out_valid_q;
  logic out_free;

  op_e op;
  logic [15:0] in_x, in_y, in_id;
  logic signed [14:0] in_hd;
  logic in_first, acc;

  assign op       = op_e'(s_axis_tuser);
  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_hd    = s_axis_tdata[46:32];
  assign in_id    = s_axis_tdata[62:47];
  assign in_first = s_axis_tdata[63];
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // squared distance of incoming target to stored pose
  logic signed [16:0] tdx, tdy;
  logic [32:0] tdist;
  logic [32:0] best_cmp;
  assign tdx = $signed({1'b0, in_x}) - $signed({1'b0, pose_x_q});
  assign tdy = $signed({1'b0, in_y}) - $signed({1'b0, pose_y_q});
  assign tdist = 33'(unsigned'(32'(tdx * tdx))) + 33'(unsigned'(32'(tdy * tdy)));
  assign best_cmp = in_first ? '1 : best_q;

  // cordic front end
  logic signed [16:0] gdx, gdy;
  cordic_t c_in, c_out;
  logic c_en, zero_vec;
  assign gdx = $signed({1'b0, goal_x_q}) - $signed({1'b0, pose_x_q});
  assign gdy = $signed({1'b0, goal_y_q}) - $signed({1'b0, pose_y_q});
  logic signed [XyW-1:0] vx, vy;
  assign vx = XyW'(gdx) <<< 8;
  assign vy = XyW'(gdy) <<< 8;
  always_comb begin
    c_in.x = vx;
    c_in.y = vy;
    c_in.z = '0;
    if (vx < 0) begin
      c_in.x = -vx;
      c_in.y = -vy;
      c_in.z = (vy >= 0) ? AngPi : -AngPi;
    end
  end

  assign c_en = (state_q == ST_CORDIC) || (state_q == ST_IDLE);

  ngsc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (c_en),
    .in_i   (c_in),
    .out_o  (c_out)
  );

  // post processing registers
  logic [47:0] mag_prod;
  logic [24:0] dist_d, dist_q;
  logic signed [AngW+1:0] err_raw, err_w;
  logic signed [AngW:0] err_d, err_q;
  logic cap_d, cap_q;
  logic [31:0] r2;
  logic [32:0] gdist;
  logic [XyW-1:0] mag_u;

  assign mag_u    = zero_vec ? '0 : unsigned'(c_out.x);
  assign mag_prod = 48'(mag_u) * 48'(InvGain);
  assign dist_d   = 25'((mag_prod + 48'd32768) >> 16);
  assign err_raw  = (zero_vec ? 26'sd0 : 26'(c_out.z)) - (26'(heading_q) <<< 8);
  always_comb begin
    err_w = err_raw;
    if (err_raw >= 26'(AngPi)) begin
      err_w = err_raw - AngTwoPi;
    end else if (err_raw < -26'(AngPi)) begin
      err_w = err_raw + AngTwoPi;
    end
  end
  assign err_d = 25'(err_w);
  assign r2    = 32'(radius_q) * 32'(radius_q);
  assign gdist = 33'(unsigned'(32'(gdx * gdx))) + 33'(unsigned'(32'(gdy * gdy)));
  assign cap_d = gdist < 33'(r2);

  logic [41:0] lin_prod_d, lin_prod_q;
  logic signed [41:0] ang_prod_d, ang_prod_q;
  assign lin_prod_d = 42'(dist_q) * 42'(lin_gain_q);
  assign ang_prod_d = 42'(err_q) * $signed({26'd0, ang_gain_q});

  logic [41:0] lin_sh;
  logic signed [41:0] ang_sh;
  logic [23:0] lin_sat;
  logic signed [23:0] ang_sat;
  assign lin_sh = (lin_prod_q + 42'd32768) >> 16;
  assign ang_sh = (ang_prod_q + 42'sd32768) >>> 16;
  assign lin_sat = (lin_sh > 42'd16777215) ? 24'hFFFFFF : lin_sh[23:0];
  always_comb begin
    if (ang_sh > 42'sd8388607) begin
      ang_sat = 24'sh7FFFFF;
    end else if (ang_sh < -42'sd8388608) begin
      ang_sat = 24'sh800000;
    end else begin
      ang_sat = ang_sh[23:0];
    end
  end

  logic zero_vec_q;
  assign zero_vec = zero_vec_q;

  always_comb begin
    state_d = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (acc && op == OP_POSE) begin
          state_d = ST_SCALE;
          if (goal_valid_q) begin
            state_d = ST_CORDIC;
          end
        end
      end
      ST_CORDIC: if (cnt_q == CntW'(NumCells - 1)) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lin_gain_q   <= 16'd2048;
      ang_gain_q   <= 16'd11520;
      radius_q     <= 16'd410;
      pose_known_q <= 1'b0;
      goal_valid_q <= 1'b0;
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      heading_q    <= '0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_id_q    <= '0;
      best_q       <= '1;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      zero_vec_q   <= 1'b0;
      dist_q       <= '0;
      err_q        <= '0;
      cap_q        <= 1'b0;
      lin_prod_q   <= '0;
      ang_prod_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_LIN_GAIN: lin_gain_q <= cfg_data_i;
          REG_ANG_GAIN: ang_gain_q <= cfg_data_i;
          REG_RADIUS:   radius_q   <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q <= (state_q == ST_CORDIC) ? cnt_q + 1'b1 : '0;
      if (acc) begin
        case (op)
          OP_POSE: begin
            pose_x_q     <= in_x;
            pose_y_q     <= in_y;
            heading_q    <= in_hd;
            pose_known_q <= 1'b1;
            zero_vec_q   <= !goal_valid_q || (goal_x_q == in_x && goal_y_q == in_y);
          end
          OP_GOAL: begin
            if (!pose_known_q) begin
              goal_valid_q <= 1'b0;
              best_q       <= '1;
            end else if (tdist < best_cmp) begin
              best_q       <= tdist;
              goal_x_q     <= in_x;
              goal_y_q     <= in_y;
              goal_id_q    <= in_id;
              goal_valid_q <= 1'b1;
            end else begin
              best_q <= best_cmp;
            end
          end
          OP_EMPTY: begin
            goal_valid_q <= 1'b0;
            best_q       <= '1;
          end
          default: ;
        endcase
      end
      if (state_q == ST_SCALE) begin
        dist_q <= dist_d;
        err_q  <= err_d;
        cap_q  <= cap_d && goal_valid_q;
      end
      if (state_q == ST_MUL) begin
        lin_prod_q <= lin_prod_d;
        ang_prod_q <= ang_prod_d;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (goal_valid_q) begin
          out_q <= {7'd0, cap_q ? goal_id_q : 16'd0, cap_q, ang_sat, lin_sat};
        end else begin
          out_q <= '0;
        end
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready) else $error("beat taken while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> m_axis_tvalid) else $error("result not presented");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0) else $error("fill bits set");
`endif

endmodule

// ----- hw/rtl/ngsc_cell.sv -----
// ----------------------------------------------------------------------------
// ngsc_cell
// one cordic vectoring micro-rotation with a tied-off shift, registered output
// ----------------------------------------------------------------------------
module ngsc_cell
  import ngsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [IdxW-1:0] idx_i,
  input  cordic_t         in_i,
  output cordic_t         out_o
);

  cordic_t out_d, out_q;
  logic signed [XyW-1:0] xs, ys;

  assign xs = in_i.x >>> idx_i;
  assign ys = in_i.y >>> idx_i;

  always_comb begin
    if (in_i.y < 0) begin
      out_d.x = in_i.x - ys;
      out_d.y = in_i.y + xs;
      out_d.z = in_i.z - atan_entry(idx_i);
    end else begin
      out_d.x = in_i.x + ys;
      out_d.y = in_i.y - xs;
      out_d.z = in_i.z + atan_entry(idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ----- hw/rtl/ngsc_chain.sv -----
// ----------------------------------------------------------------------------
// ngsc_chain
// row of cordic cells; data moves one cell per enabled cycle
// ----------------------------------------------------------------------------
module ngsc_chain
  import ngsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  cordic_t in_i,
  output cordic_t out_o
);

  cordic_t link [NumCells+1];

  assign link[0] = in_i;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    ngsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .idx_i  (IdxW'(g)),
      .in_i   (link[g]),
      .out_o  (link[g+1])
    );
  end

  assign out_o = link[NumCells];

endmodule

// ----- verif/nearest_goal_steering_controller_core_test.sv -----
// ----------------------------------------------------------------------------
// nearest_goal_steering_controller_core_test
// stream-level check of the nearest-goal steering core: target lists and pose
// beats are driven with random gaps, commands are compared against a local
// fixed-point predictor, and the gains and capture radius are swept by phase
// ----------------------------------------------------------------------------
module nearest_goal_steering_controller_core_test;
  import ngsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        first;
    logic [15:0] gid;
    logic [14:0] hdg;
    logic [15:0] py;
    logic [15:0] px;
    op_e         op;
  } beat_t;

  typedef struct {
    logic [23:0] lin;
    logic [23:0] angv;
    logic        cap;
    logic [15:0] cap_id;
  } cmd_t;

  localparam longint PiQ20   = 3294199;
  localparam longint AllOnes = 64'h1_FFFF_FFFF;
  localparam int     IdleLim = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  beat_t  pending_beats[$];
  cmd_t   expected_cmds[$];
  int     fail_count = 0;
  int     cmd_count = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;

  // predictor state
  longint lin_gain = 2048, ang_gain = 11520, radius = 410;
  bit     pose_known = 0, goal_valid = 0;
  longint pose_x = 0, pose_y = 0, pose_hdg = 0;
  longint goal_x = 0, goal_y = 0, goal_id = 0;
  longint best_d2 = AllOnes;

  always #5 clk_i = ~clk_i;

  nearest_goal_steering_controller_core dut (.*);

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q20(int i);
    longint tab[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? tab[i] : 0;
  endfunction

  function automatic void steer_apply(beat_t b);
    longint d2, dx, dy, x, y, z, xs, ys, dist_v, err, lin, angv;
    cmd_t c;
    case (b.op)
      OP_GOAL: begin
        if (!pose_known) begin
          goal_valid = 0;
          best_d2 = AllOnes;
        end else begin
          if (b.first) best_d2 = AllOnes;
          d2 = (b.px - pose_x) * (b.px - pose_x) + (b.py - pose_y) * (b.py - pose_y);
          if (d2 < best_d2) begin
            best_d2 = d2;
            goal_x = b.px;
            goal_y = b.py;
            goal_id = b.gid;
            goal_valid = 1;
          end
        end
      end
      OP_EMPTY: begin
        goal_valid = 0;
        best_d2 = AllOnes;
      end
      OP_POSE: begin
        pose_x = b.px;
        pose_y = b.py;
        pose_hdg = longint'($signed(b.hdg));
        pose_known = 1;
        c = '{24'd0, 24'd0, 1'b0, 16'd0};
        if (goal_valid) begin
          dx = (goal_x - pose_x) * 256;
          dy = (goal_y - pose_y) * 256;
          x = dx;
          y = dy;
          z = 0;
          if (x != 0 || y != 0) begin
            if (x < 0) begin
              z = (y >= 0) ? PiQ20 : -PiQ20;
              x = -x;
              y = -y;
            end
            for (int i = 0; i < CordicSteps && i < MaxTable; i++) begin
              xs = floor_shr(x, i);
              ys = floor_shr(y, i);
              if (y < 0) begin
                x -= ys; y += xs; z -= atan_q20(i);
              end else begin
                x += ys; y -= xs; z += atan_q20(i);
              end
            end
          end else x = 0;
          dist_v = (x * 39797 + 32768) >>> 16;
          err = z - pose_hdg * 256;
          while (err >= PiQ20) err -= 2 * PiQ20;
          while (err < -PiQ20) err += 2 * PiQ20;
          lin = (lin_gain * dist_v + 32768) >>> 16;
          if (lin < 0) lin = 0;
          if (lin > 16777215) lin = 16777215;
          angv = floor_shr(ang_gain * err + 32768, 16);
          if (angv < -8388608) angv = -8388608;
          if (angv > 8388607) angv = 8388607;
          c.lin = lin[23:0];
          c.angv = angv[23:0];
          d2 = (goal_x - pose_x) * (goal_x - pose_x) + (goal_y - pose_y) * (goal_y - pose_y);
          if (d2 < radius * radius) begin
            c.cap = 1'b1;
            c.cap_id = goal_id[15:0];
          end
        end
        expected_cmds.push_back(c);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      steer_apply(beat_t'({s_axis_tdata, s_axis_tuser}));
      void'(pending_beats.pop_front());
    end
    if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 21) &&
        !(s_axis_tvalid && s_axis_tready && pending_beats.size() == 0)) begin
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tdata, s_axis_tuser} <= pending_beats[0];
      end
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      s_axis_tvalid <= 1'b0;
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 21);
  end

  // monitor
  always @(posedge clk_i) begin
    cmd_t e;
    if (rst_ni && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      cmd_count++;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command beat %h", m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_cmds.pop_front();
        if (m_axis_tdata[23:0] !== e.lin) begin
          $error("linear_speed exp %0d got %0d", e.lin, m_axis_tdata[23:0]);
          fail_count++;
        end
        if (m_axis_tdata[47:24] !== e.angv) begin
          $error("angular_speed exp %0d got %0d", $signed(e.angv),
                 $signed(m_axis_tdata[47:24]));
          fail_count++;
        end
        if (m_axis_tdata[48] !== e.cap) begin
          $error("capture_request exp %0d got %0d", e.cap, m_axis_tdata[48]);
          fail_count++;
        end
        if (m_axis_tdata[64:49] !== e.cap_id) begin
          $error("capture_id exp %0d got %0d", e.cap_id, m_axis_tdata[64:49]);
          fail_count++;
        end
      end
    end
    if (idle_cycles > IdleLim) begin
      $display("watchdog: no beat for %0d cycles", IdleLim);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic beat_t rand_beat(op_e op, bit first);
    beat_t b;
    b.op = op;
    b.first = first;
    b.gid = 16'($urandom);
    b.hdg = 15'($signed($urandom_range(25736)) - 12868);
    if ($urandom_range(3) == 0) begin
      b.px = 16'($urandom);
      b.py = 16'($urandom);
    end else begin
      b.px = 16'($urandom_range(4096) + 30000);
      b.py = 16'($urandom_range(4096) + 30000);
    end
    return b;
  endfunction

  function automatic beat_t mk(op_e op, int px, int py, int hdg, int gid, bit first);
    beat_t b;
    b.op = op; b.px = px[15:0]; b.py = py[15:0]; b.hdg = hdg[14:0];
    b.gid = gid[15:0]; b.first = first;
    return b;
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LIN_GAIN: lin_gain = val;
      REG_ANG_GAIN: ang_gain = val;
      REG_RADIUS:   radius = val;
      default: ;
    endcase
  endtask

  task automatic random_lists(int n);
    int k;
    int m;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin pending_beats.push_back(rand_beat(OP_EMPTY, $urandom_range(1))); k++; end
        1: begin pending_beats.push_back(rand_beat(OP_NONE, $urandom_range(1))); end
        2, 3, 4: begin pending_beats.push_back(rand_beat(OP_POSE, $urandom_range(1))); k++; end
        default: begin
          m = $urandom_range(4);
          for (int j = 0; j <= m; j++) begin
            pending_beats.push_back(rand_beat(OP_GOAL, j == 0 ? 1'b1 : $urandom_range(7) == 0));
            k++;
          end
          pending_beats.push_back(rand_beat(OP_POSE, $urandom_range(1)));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] lg[4] = '{16'd0, 16'hFFFF, 16'd2048, 16'd300};
    logic [15:0] ag[4] = '{16'hFFFF, 16'd0, 16'd11520, 16'd77};
    logic [15:0] rd[4] = '{16'hFFFF, 16'd0, 16'd410, 16'd3000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: goals before pose, no-goal pose, ties, empty list, extremes
    pending_beats.push_back(mk(OP_GOAL, 100, 100, 0, 1, 1));
    pending_beats.push_back(mk(OP_POSE, 0, 0, 12868, 0, 0));
    pending_beats.push_back(mk(OP_GOAL, 65535, 65535, 0, 65535, 1));
    pending_beats.push_back(mk(OP_POSE, 0, 0, -12868, 0, 1));
    pending_beats.push_back(mk(OP_GOAL, 10, 0, 0, 2, 1));
    pending_beats.push_back(mk(OP_GOAL, 0, 10, 0, 3, 0));
    pending_beats.push_back(mk(OP_POSE, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_GOAL, 0, 0, 0, 4, 1));
    pending_beats.push_back(mk(OP_POSE, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_POSE, 65535, 0, 16383, 0, 0));
    pending_beats.push_back(mk(OP_GOAL, 0, 65535, 0, 5, 0));
    pending_beats.push_back(mk(OP_POSE, 65535, 65535, 0, 0, 0));
    pending_beats.push_back(mk(OP_GOAL, 65535, 0, 0, 6, 1));
    pending_beats.push_back(mk(OP_POSE, 65535, 65535, -16384, 0, 0));
    pending_beats.push_back(mk(OP_GOAL, 0, 0, 0, 7, 1));
    pending_beats.push_back(mk(OP_POSE, 65535, 32768, 100, 0, 0));
    pending_beats.push_back(mk(OP_NONE, 1, 1, 1, 1, 1));
    pending_beats.push_back(mk(OP_EMPTY, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_POSE, 5, 5, 0, 0, 0));
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_LIN_GAIN, lg[p]);
      write_reg(REG_ANG_GAIN, ag[p]);
      write_reg(REG_RADIUS, rd[p]);
      calm = (p == 2);
      random_lists(150);
      drain();
    end
    $display("covered directed corners and about 600 random beats over 4 gain/radius sets,");
    $display("%0d command beats checked", cmd_count);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
